>>> rtl/assert_macros.svh
// Assertion macros shared by the queue manager RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tpq_pkg.sv
// Shared types and constants for the two-class priority queue manager
`timescale 1ns / 1ps

package tpq_pkg;

	localparam int CAP_W           = 6;
	localparam int LVL_W           = 6;
	localparam int IN_TAG_W        = 32;
	localparam int OUT_TAG_W       = 32;
	localparam int STAT_W          = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int TAG_BITS_DEF    = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	localparam logic MODE_ARRIVE = 1'b0;
	localparam logic MODE_TICK   = 1'b1;
	localparam logic CLASS_HIGH  = 1'b0;
	localparam logic CLASS_LOW   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_CAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_CAP  = 1'b1;

	typedef enum logic [1:0] {
		OP_ARRIVE_HIGH = 2'd0,
		OP_ARRIVE_LOW  = 2'd1,
		OP_TICK        = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [IN_TAG_W-1:0]   tag;
	} op_t;

	typedef struct packed {
		logic arrive;
		logic deq;
	} cls_ctl_t;

	typedef struct packed {
		logic room;
		logic nonempty;
	} cls_flags_t;

endpackage

>>> rtl/two_class_priority_queue_tail_drop.sv
// Top level of the two-class strict-priority output queue with tail drop
`timescale 1ns / 1ps

// Takes one beat per clock while in_ready is high, either a packet arrival
// or a service tick, and returns one result beat for each. Sustained rate
// is one beat per cycle while out_ready stays high. A taken beat waits in
// the two-entry front buffer, and the execute step then updates the class
// FIFO and loads the result register that drives out_valid. The execute
// step is the single point where pointers, fills, sums and counts change,
// so the tick priority decision always sees the previous beat's state.
// Each class store is a memory with one write and one registered read
// port; it is not cleared after reset. The user must write the high and
// low capacities through the cfg port only while no beat is in flight;
// the block itself does not enforce this.
module two_class_priority_queue_tail_drop import tpq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CAP_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic                  packet_class,
	input  logic [IN_TAG_W-1:0]   packet_tag,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic                  dropped,
	output logic                  sent,
	output logic                  sent_class,
	output logic [OUT_TAG_W-1:0]  sent_tag,
	output logic [LVL_W-1:0]      high_level,
	output logic [LVL_W-1:0]      low_level,
	output logic [STAT_W-1:0]     high_level_sum,
	output logic [STAT_W-1:0]     high_samples,
	output logic [STAT_W-1:0]     low_level_sum,
	output logic [STAT_W-1:0]     low_samples
);

	logic op_valid;
	logic op_ready;
	op_t  op;

	tpq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.packet_class (packet_class),
		.packet_tag   (packet_tag),
		.op_valid     (op_valid),
		.op           (op),
		.op_ready     (op_ready)
	);

	tpq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op_valid       (op_valid),
		.op             (op),
		.op_ready       (op_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.dropped        (dropped),
		.sent           (sent),
		.sent_class     (sent_class),
		.sent_tag       (sent_tag),
		.high_level     (high_level),
		.low_level      (low_level),
		.high_level_sum (high_level_sum),
		.high_samples   (high_samples),
		.low_level_sum  (low_level_sum),
		.low_samples    (low_samples)
	);

endmodule

>>> rtl/tpq_front.sv
// Front end: accepts beats, classifies them and buffers them for the back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpq_front import tpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic                packet_class,
	input  logic [IN_TAG_W-1:0] packet_tag,
	output logic                op_valid,
	output op_t                 op,
	input  logic                op_ready
);

	localparam int SLOTS = 2;

	op_t        slot_q [SLOTS];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	op_t        op_in;

	always_comb begin
		op_in.tag = packet_tag;
		if (mode == MODE_TICK) begin
			op_in.kind = OP_TICK;
		end else if (packet_class == CLASS_HIGH) begin
			op_in.kind = OP_ARRIVE_HIGH;
		end else begin
			op_in.kind = OP_ARRIVE_LOW;
		end
	end

	assign in_ready = cnt_q != 2'(SLOTS);
	assign op_valid = cnt_q != 2'd0;
	assign op       = slot_q[rptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`TPQ_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= 2'(SLOTS), "front queue overflow")

endmodule

>>> rtl/tpq_class.sv
// One class FIFO: tag store, pointers, fill, occupancy sum and arrival count
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpq_class import tpq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [CAP_W-1:0]                     cap,
	input  cls_ctl_t                             ctl,
	input  logic [IN_TAG_W-1:0]                  tag,
	output cls_flags_t                           flags,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]     fill,
	output logic [STAT_W-1:0]                    sum,
	output logic [STAT_W-1:0]                    count,
	output logic [TAG_BITS-1:0]                  rd_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW = (FW > CAP_W) ? FW : CAP_W;

	logic [TAG_BITS-1:0] mem [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] rd_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [FW-1:0]       fill_q;
	logic [STAT_W-1:0]   sum_q;
	logic [STAT_W-1:0]   count_q;
	logic [CW-1:0]       cap_eff;
	logic [CW-1:0]       fill_ext;
	logic [CW-1:0]       addend;
	logic [STAT_W:0]     sum_wide;
	logic [63:0]         tag_wide;
	logic                push;

	always_comb begin
		fill_ext       = CW'(fill_q);
		cap_eff        = (CW'(cap) > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(cap);
		flags.room     = fill_ext < cap_eff;
		flags.nonempty = fill_q != '0;
		push           = ctl.arrive && flags.room;
		addend         = flags.room ? fill_ext + CW'(1) : cap_eff;
		sum_wide       = {1'b0, sum_q} + (STAT_W+1)'(addend);
		tag_wide       = 64'(tag);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= tag_wide[TAG_BITS-1:0];
		end
		if (ctl.deq) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			if (ctl.arrive) begin
				sum_q <= sum_wide[STAT_W] ? '1 : sum_wide[STAT_W-1:0];
				if (count_q != '1) begin
					count_q <= count_q + STAT_W'(1);
				end
			end
			if (push) begin
				tail_q <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
				fill_q <= fill_q + FW'(1);
			end else if (ctl.deq) begin
				head_q <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	assign fill    = fill_q;
	assign sum     = sum_q;
	assign count   = count_q;
	assign rd_data = rd_q;

	`TPQ_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FW'(QUEUE_DEPTH), "fill past depth")
	`TPQ_ASSERT_IMP(a_deq_nonempty, clk, arst_n, ctl.deq, fill_q != '0, "dequeue from empty")
	`TPQ_ASSERT_NXT(a_push_fill, clk, arst_n, push, fill_q == $past(fill_q) + FW'(1), "fill not bumped")

endmodule

>>> rtl/tpq_back.sv
// Back end: capacity registers, strict-priority execute and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpq_back import tpq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CAP_W-1:0]      cfg_data,
	input  logic                  op_valid,
	input  op_t                   op,
	output logic                  op_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic                  dropped,
	output logic                  sent,
	output logic                  sent_class,
	output logic [OUT_TAG_W-1:0]  sent_tag,
	output logic [LVL_W-1:0]      high_level,
	output logic [LVL_W-1:0]      low_level,
	output logic [STAT_W-1:0]     high_level_sum,
	output logic [STAT_W-1:0]     high_samples,
	output logic [STAT_W-1:0]     low_level_sum,
	output logic [STAT_W-1:0]     low_samples
);

	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW = (FW > LVL_W) ? FW : LVL_W;

	logic [CAP_W-1:0]    hi_cap_q;
	logic [CAP_W-1:0]    lo_cap_q;
	cls_ctl_t            hi_ctl;
	cls_ctl_t            lo_ctl;
	cls_flags_t          hi_flags;
	cls_flags_t          lo_flags;
	logic [FW-1:0]       hi_fill;
	logic [FW-1:0]       lo_fill;
	logic [TAG_BITS-1:0] hi_rd;
	logic [TAG_BITS-1:0] lo_rd;
	logic [TAG_BITS-1:0] rd_sel;
	logic [63:0]         rd_wide;
	logic [CW-1:0]       hi_lvl_ext;
	logic [CW-1:0]       lo_lvl_ext;
	logic                fire;
	logic                acc_d;
	logic                drp_d;
	logic                valid_q;
	logic                accepted_q;
	logic                dropped_q;
	logic                sent_q;
	logic                sent_class_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_cap_q <= CAP_RESET;
			lo_cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HIGH_CAP: hi_cap_q <= cfg_data;
				REG_LOW_CAP:  lo_cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign op_ready = !valid_q || out_ready;
	assign fire     = op_valid && op_ready;

	always_comb begin
		hi_ctl = '0;
		lo_ctl = '0;
		unique case (op.kind)
			OP_ARRIVE_HIGH: hi_ctl.arrive = fire;
			OP_ARRIVE_LOW:  lo_ctl.arrive = fire;
			OP_TICK: begin
				hi_ctl.deq = fire && hi_flags.nonempty;
				lo_ctl.deq = fire && !hi_flags.nonempty && lo_flags.nonempty;
			end
			default: ;
		endcase
		acc_d = (hi_ctl.arrive && hi_flags.room) || (lo_ctl.arrive && lo_flags.room);
		drp_d = (hi_ctl.arrive && !hi_flags.room) || (lo_ctl.arrive && !lo_flags.room);
	end

	tpq_class #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_high (
		.clk     (clk),
		.arst_n  (arst_n),
		.cap     (hi_cap_q),
		.ctl     (hi_ctl),
		.tag     (op.tag),
		.flags   (hi_flags),
		.fill    (hi_fill),
		.sum     (high_level_sum),
		.count   (high_samples),
		.rd_data (hi_rd)
	);

	tpq_class #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_low (
		.clk     (clk),
		.arst_n  (arst_n),
		.cap     (lo_cap_q),
		.ctl     (lo_ctl),
		.tag     (op.tag),
		.flags   (lo_flags),
		.fill    (lo_fill),
		.sum     (low_level_sum),
		.count   (low_samples),
		.rd_data (lo_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q   <= acc_d;
			dropped_q    <= drp_d;
			sent_q       <= hi_ctl.deq || lo_ctl.deq;
			sent_class_q <= lo_ctl.deq;
		end
	end

	// class state only moves on fire, so it already reflects the waiting beat
	always_comb begin
		rd_sel     = sent_class_q ? lo_rd : hi_rd;
		rd_wide    = 64'(rd_sel);
		hi_lvl_ext = CW'(hi_fill);
		lo_lvl_ext = CW'(lo_fill);
	end

	assign out_valid  = valid_q;
	assign accepted   = accepted_q;
	assign dropped    = dropped_q;
	assign sent       = sent_q;
	assign sent_class = sent_class_q;
	assign sent_tag   = sent_q ? rd_wide[OUT_TAG_W-1:0] : '0;
	assign high_level = hi_lvl_ext[LVL_W-1:0];
	assign low_level  = lo_lvl_ext[LVL_W-1:0];

	`TPQ_ASSERT_IMP(a_no_fire_stalled, clk, arst_n, valid_q && !out_ready, !fire, "overwrite of held beat")
	`TPQ_ASSERT_IMP(a_result_onehot, clk, arst_n, valid_q, $onehot0({accepted_q, dropped_q, sent_q}), "mixed result flags")

endmodule

>>> tb/sv/two_class_priority_queue_tail_drop_tb.sv
// Testbench for the two-class strict-priority queue with tail drop
`timescale 1ns / 1ps

module two_class_priority_queue_tail_drop_tb;
	import tpq_pkg::*;

	localparam int DEPTH      = QUEUE_DEPTH_DEF;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 104;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_LEN   = 200;

	typedef struct packed {
		logic                 accepted;
		logic                 dropped;
		logic                 sent;
		logic                 sent_class;
		logic [OUT_TAG_W-1:0] sent_tag;
		logic [LVL_W-1:0]     high_level;
		logic [LVL_W-1:0]     low_level;
		logic [STAT_W-1:0]    high_level_sum;
		logic [STAT_W-1:0]    high_samples;
		logic [STAT_W-1:0]    low_level_sum;
		logic [STAT_W-1:0]    low_samples;
	} outcome_t;

	typedef enum logic {
		ROW_BEAT,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 mode;
		logic                 cls;
		logic [IN_TAG_W-1:0]  tag;
		logic [CFG_IDX_W-1:0] cfg_reg;
		logic [CAP_W-1:0]     cfg_val;
		logic                 typed;
		outcome_t             want;
	} row_t;

	// typed rows: acc, drop, sent, class, tag, hlvl, llvl, hsum, hcnt, lsum, lcnt
	localparam row_t PLAN [23] = '{
		'{ROW_BEAT, MODE_TICK, CLASS_HIGH, 32'h0000_0000, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b0, 1'b0, 1'b0, CLASS_HIGH, 32'h0, 6'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_HIGH, 32'hFFFF_FFFF, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b1, 1'b0, 1'b0, CLASS_HIGH, 32'h0, 6'd1, 6'd0, 32'd1, 32'd1, 32'd0, 32'd0}},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_LOW, 32'h0000_0000, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b1, 1'b0, 1'b0, CLASS_HIGH, 32'h0, 6'd1, 6'd1, 32'd1, 32'd1, 32'd1, 32'd1}},
		'{ROW_BEAT, MODE_TICK, CLASS_LOW, 32'hDEAD_BEEF, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b0, 1'b0, 1'b1, CLASS_HIGH, 32'hFFFF_FFFF, 6'd0, 6'd1,
				32'd1, 32'd1, 32'd1, 32'd1}},
		'{ROW_BEAT, MODE_TICK, CLASS_HIGH, 32'h0000_0000, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b0, 1'b0, 1'b1, CLASS_LOW, 32'h0, 6'd0, 6'd0, 32'd1, 32'd1, 32'd1, 32'd1}},
		'{ROW_BEAT, MODE_TICK, CLASS_LOW, 32'hFFFF_FFFF, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b0, 1'b0, 1'b0, CLASS_HIGH, 32'h0, 6'd0, 6'd0, 32'd1, 32'd1, 32'd1, 32'd1}},
		'{ROW_CFG, MODE_ARRIVE, CLASS_HIGH, 32'h0, REG_HIGH_CAP, 6'd1, 1'b0, '0},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_HIGH, 32'hA5A5_A5A5, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b1, 1'b0, 1'b0, CLASS_HIGH, 32'h0, 6'd1, 6'd0, 32'd2, 32'd2, 32'd1, 32'd1}},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_HIGH, 32'h5A5A_5A5A, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b0, 1'b1, 1'b0, CLASS_HIGH, 32'h0, 6'd1, 6'd0, 32'd3, 32'd3, 32'd1, 32'd1}},
		'{ROW_CFG, MODE_ARRIVE, CLASS_HIGH, 32'h0, REG_LOW_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_LOW, 32'h1234_5678, REG_HIGH_CAP, 6'd0, 1'b1,
			'{1'b0, 1'b1, 1'b0, CLASS_HIGH, 32'h0, 6'd1, 6'd0, 32'd3, 32'd3, 32'd1, 32'd2}},
		'{ROW_CFG, MODE_ARRIVE, CLASS_HIGH, 32'h0, REG_LOW_CAP, 6'd63, 1'b0, '0},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_LOW, 32'h8000_0001, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_LOW, 32'h7FFF_FFFE, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_CFG, MODE_ARRIVE, CLASS_HIGH, 32'h0, REG_LOW_CAP, 6'd1, 1'b0, '0},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_LOW, 32'h0F0F_0F0F, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_TICK, CLASS_LOW, 32'h0, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_TICK, CLASS_HIGH, 32'h0, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_LOW, 32'hF0F0_F0F0, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_TICK, CLASS_HIGH, 32'h0, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_ARRIVE, CLASS_LOW, 32'h3C3C_3C3C, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_TICK, CLASS_HIGH, 32'h0, REG_HIGH_CAP, 6'd0, 1'b0, '0},
		'{ROW_BEAT, MODE_TICK, CLASS_LOW, 32'h0, REG_HIGH_CAP, 6'd0, 1'b0, '0}
	};

	localparam logic [CAP_W-1:0] PHASE_HIGH_CAP [PHASES-1] = '{
		6'd32, 6'd63, 6'd0, 6'd4, 6'd1, 6'd63, 6'd2
	};
	localparam logic [CAP_W-1:0] PHASE_LOW_CAP [PHASES-1] = '{
		6'd32, 6'd63, 6'd5, 6'd0, 6'd1, 6'd2, 6'd63
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAP_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic                 packet_class;
	logic [IN_TAG_W-1:0]  packet_tag;
	logic                 out_valid;
	logic                 out_ready;
	logic                 accepted;
	logic                 dropped;
	logic                 sent;
	logic                 sent_class;
	logic [OUT_TAG_W-1:0] sent_tag;
	logic [LVL_W-1:0]     high_level;
	logic [LVL_W-1:0]     low_level;
	logic [STAT_W-1:0]    high_level_sum;
	logic [STAT_W-1:0]    high_samples;
	logic [STAT_W-1:0]    low_level_sum;
	logic [STAT_W-1:0]    low_samples;

	// predictor state, indexed by class
	logic [IN_TAG_W-1:0] tag_mem [2][DEPTH];
	int unsigned         rd_ptr [2];
	int unsigned         wr_ptr [2];
	int unsigned         occupancy [2];
	longint unsigned     occ_sum [2];
	longint unsigned     arrivals [2];
	int unsigned         capacity [2];

	outcome_t awaited_outcomes [$];
	int       mismatches;
	int       results_seen;
	int       send_calm;
	bit       send_quiet;

	two_class_priority_queue_tail_drop dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.packet_class  (packet_class),
		.packet_tag    (packet_tag),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.accepted      (accepted),
		.dropped       (dropped),
		.sent          (sent),
		.sent_class    (sent_class),
		.sent_tag      (sent_tag),
		.high_level    (high_level),
		.low_level     (low_level),
		.high_level_sum(high_level_sum),
		.high_samples  (high_samples),
		.low_level_sum (low_level_sum),
		.low_samples   (low_samples)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint unsigned sat32(longint unsigned v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic outcome_t advance_queues(logic op, logic cls, logic [IN_TAG_W-1:0] tag);
		outcome_t    o;
		int unsigned lim;
		int          q;
		o = '0;
		if (op == MODE_ARRIVE) begin
			q = (cls == CLASS_HIGH) ? 0 : 1;
			lim = (capacity[q] > DEPTH) ? DEPTH : capacity[q];
			arrivals[q] = sat32(arrivals[q] + 1);
			if (occupancy[q] < lim) begin
				tag_mem[q][wr_ptr[q]] = tag;
				wr_ptr[q] = (wr_ptr[q] + 1) % DEPTH;
				occupancy[q]++;
				occ_sum[q] = sat32(occ_sum[q] + occupancy[q]);
				o.accepted = 1'b1;
			end else begin
				occ_sum[q] = sat32(occ_sum[q] + lim);
				o.dropped = 1'b1;
			end
		end else begin
			q = (occupancy[0] > 0) ? 0 : (occupancy[1] > 0) ? 1 : -1;
			if (q >= 0) begin
				o.sent = 1'b1;
				o.sent_class = (q == 0) ? CLASS_HIGH : CLASS_LOW;
				o.sent_tag = tag_mem[q][rd_ptr[q]];
				rd_ptr[q] = (rd_ptr[q] + 1) % DEPTH;
				occupancy[q]--;
			end
		end
		o.high_level = LVL_W'(occupancy[0]);
		o.low_level = LVL_W'(occupancy[1]);
		o.high_level_sum = occ_sum[0][31:0];
		o.high_samples = arrivals[0][31:0];
		o.low_level_sum = occ_sum[1][31:0];
		o.low_samples = arrivals[1][31:0];
		return o;
	endfunction

	// entered and left at a falling edge
	task automatic send_beat(logic op, logic cls, logic [IN_TAG_W-1:0] tag,
			logic typed, outcome_t want);
		outcome_t predicted;
		int       gap;
		in_valid = 1'b1;
		mode = op;
		packet_class = cls;
		packet_tag = tag;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = advance_queues(op, cls, tag);
		awaited_outcomes.push_back(typed ? want : predicted);
		@(negedge clk);
		if (send_calm == 0) begin
			send_calm = $urandom_range(20, 60);
			send_quiet = ($urandom_range(0, 3) == 0);
		end
		send_calm--;
		gap = send_quiet ? 0 : gap_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_cap(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
		in_valid = 1'b0;
		while (awaited_outcomes.size() != 0) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		capacity[(idx == REG_HIGH_CAP) ? 0 : 1] = 32'(val);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		outcome_t exp_o;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			results_seen++;
			if (awaited_outcomes.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				exp_o = awaited_outcomes.pop_front();
				check_field("accepted", 32'(exp_o.accepted), 32'(accepted));
				check_field("dropped", 32'(exp_o.dropped), 32'(dropped));
				check_field("sent", 32'(exp_o.sent), 32'(sent));
				check_field("sent_class", 32'(exp_o.sent_class), 32'(sent_class));
				check_field("sent_tag", exp_o.sent_tag, sent_tag);
				check_field("high_level", 32'(exp_o.high_level), 32'(high_level));
				check_field("low_level", 32'(exp_o.low_level), 32'(low_level));
				check_field("high_level_sum", exp_o.high_level_sum, high_level_sum);
				check_field("high_samples", exp_o.high_samples, high_samples);
				check_field("low_level_sum", exp_o.low_level_sum, low_level_sum);
				check_field("low_samples", exp_o.low_samples, low_samples);
			end
		end
	end

	initial begin : drain_side
		int stall_left;
		int calm_left;
		bit quiet;
		bit held;
		stall_left = 0;
		calm_left = 0;
		quiet = 1'b0;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			// long hold-off so the block backs up and stalls its input
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end
			if (calm_left == 0) begin
				calm_left = $urandom_range(30, 120);
				quiet = ($urandom_range(0, 3) == 0);
			end
			calm_left--;
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if (!quiet) stall_left = gap_len();
			end
		end
	end

	initial begin : feed_side
		int               seg_left;
		int               arrive_pct;
		int               high_pct;
		logic             op;
		logic             cls;
		logic [CAP_W-1:0] hcap;
		logic [CAP_W-1:0] lcap;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_HIGH_CAP;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_ARRIVE;
		packet_class = CLASS_HIGH;
		packet_tag = '0;
		mismatches = 0;
		results_seen = 0;
		send_calm = 0;
		send_quiet = 1'b0;
		for (int k = 0; k < 2; k++) begin
			rd_ptr[k] = 0;
			wr_ptr[k] = 0;
			occupancy[k] = 0;
			occ_sum[k] = 0;
			arrivals[k] = 0;
			capacity[k] = 32'(CAP_RESET);
		end
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG)
				write_cap(PLAN[i].cfg_reg, PLAN[i].cfg_val);
			else
				send_beat(PLAN[i].mode, PLAN[i].cls, PLAN[i].tag, PLAN[i].typed, PLAN[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			hcap = (p < PHASES - 1) ? PHASE_HIGH_CAP[p] : CAP_W'($urandom_range(0, 63));
			lcap = (p < PHASES - 1) ? PHASE_LOW_CAP[p] : CAP_W'($urandom_range(0, 63));
			write_cap(REG_HIGH_CAP, hcap);
			write_cap(REG_LOW_CAP, lcap);
			seg_left = 0;
			arrive_pct = 50;
			high_pct = 50;
			for (int n = 0; n < PHASE_LEN; n++) begin
				// bursts that fill, drain or churn the queues
				if (seg_left == 0) begin
					seg_left = $urandom_range(1, 40);
					case ($urandom_range(0, 2))
						0: arrive_pct = 90;
						1: arrive_pct = 50;
						default: arrive_pct = 10;
					endcase
					case ($urandom_range(0, 2))
						0: high_pct = 80;
						1: high_pct = 50;
						default: high_pct = 20;
					endcase
				end
				seg_left--;
				op = ($urandom_range(0, 99) < arrive_pct) ? MODE_ARRIVE : MODE_TICK;
				cls = ($urandom_range(0, 99) < high_pct) ? CLASS_HIGH : CLASS_LOW;
				send_beat(op, cls, $urandom(), 1'b0, '0);
			end
		end

		in_valid = 1'b0;
		while (awaited_outcomes.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
